// ----- rtl/bpe_pkg.sv -----
`default_nettype none
package bpe_pkg;
    localparam int AXES = 3;
    localparam int CFG_BITS = 4;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/bpe_cell.sv -----
`default_nettype none
// One slot of the cascade: holds a point, lerps toward its right neighbor.
module bpe_cell
    import bpe_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 load,
    input  wire  logic signed [COORD_BITS-1:0]  load_pt [AXES],
    input  wire                                 step,
    input  wire  logic        [T_FRAC_BITS-1:0] t,
    input  wire  logic signed [COORD_BITS-1:0]  right_pt [AXES],
    output logic signed [COORD_BITS-1:0]        pt [AXES]
);
    logic signed [COORD_BITS-1:0] pt_reg  [AXES];
    logic signed [COORD_BITS-1:0] pt_next [AXES];

    // lerp per axis, round to nearest
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            logic signed [COORD_BITS:0] d;
            logic signed [COORD_BITS+T_FRAC_BITS+1:0] p;
            d = COORD_BITS'(0) + ({right_pt[k][COORD_BITS-1], right_pt[k]}
                - {pt_reg[k][COORD_BITS-1], pt_reg[k]});
            p = d * $signed({1'b0, t})
                + $signed((COORD_BITS+T_FRAC_BITS+2)'(1) <<< (T_FRAC_BITS-1));
            pt_next[k] = pt_reg[k]
                + COORD_BITS'(p[COORD_BITS+T_FRAC_BITS+1:T_FRAC_BITS]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < AXES; k++)
        begin
            if (load)
                pt_reg[k] <= load_pt[k];
            else if (step)
                pt_reg[k] <= pt_next[k];
        end
    end

    assign pt = pt_reg;
endmodule
`default_nettype wire

// ----- rtl/bezier_point_eval_unit.sv -----
`default_nettype none
// Channel      | dir | contents
// s_axis       | in  | tdata: point_index, coord_x, coord_y, coord_z, t_param; tuser: action
// m_axis       | out | tdata: curve_x, curve_y, curve_z
// cfg          | in  | point_count
// Load: the point is written to the store. Evaluate: the cells copy the store at the
// accepting edge, then all cells step in parallel through the cascade.
// The result is then held in cell 0's register until it is drained.
// Next word is taken only while idle, once no result is held or the held one is being drained.
// rst_n async clears control; point store is undefined until written.
module bezier_point_eval_unit
    import bpe_pkg::*;
#(
    parameter int MAX_POINTS = 8,
    parameter int COORD_BITS = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    // point_index[2:0], coord_x, coord_y, coord_z, t_param, zero fill
    input  wire  logic [((3+3*COORD_BITS+T_FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire  logic         s_axis_tuser, // action
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    // curve_x, curve_y, curve_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  logic [CFG_BITS-1:0] cfg_data
);
    localparam int IB = 3;
    localparam int CB = $clog2(MAX_POINTS + 1) > CFG_BITS ? $clog2(MAX_POINTS + 1) : CFG_BITS;
    localparam int OW = ((3*COORD_BITS+7)/8)*8;

    typedef enum logic [1:0] { ST_IDLE = 2'b01, ST_RUN = 2'b10 } state_t;
    state_t state_reg, state_next;

    logic [CFG_BITS-1:0] count_reg;
    logic [CB-1:0] n_eff, left_reg;
    logic [T_FRAC_BITS-1:0] t_reg;
    logic signed [COORD_BITS-1:0] store [MAX_POINTS][AXES];
    logic signed [COORD_BITS-1:0] cpt [MAX_POINTS+1][AXES];
    logic signed [COORD_BITS-1:0] in_pt [AXES];
    logic [IB-1:0] idx;
    logic acc, ld, copy, step;
    logic [OW-1:0] out_word;
    logic ov_reg;

    assign idx = s_axis_tdata[IB-1:0];
    for (genvar k = 0; k < AXES; k++)
    begin : g_in
        assign in_pt[k] = s_axis_tdata[IB+k*COORD_BITS +: COORD_BITS];
    end

    // saturate point count
    always_comb
    begin
        if (CB'(count_reg) < CB'(2))
            n_eff = CB'(2);
        else if (CB'(count_reg) > CB'(MAX_POINTS))
            n_eff = CB'(MAX_POINTS);
        else
            n_eff = CB'(count_reg);
    end

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!ov_reg || m_axis_tready);
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign ld   = acc && (s_axis_tuser == ACT_LOAD) && (CB'(idx) < n_eff);
    assign copy = acc && (s_axis_tuser == ACT_EVAL);
    assign step = (state_reg == ST_RUN);

    // point store
    always_ff @(posedge clk)
    begin
        if (ld)
            for (int k = 0; k < AXES; k++)
                store[idx][k] <= in_pt[k];
    end

    // cell row
    for (genvar k = 0; k < AXES; k++)
    begin : g_pad
        assign cpt[MAX_POINTS][k] = '0;
    end
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        bpe_cell #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_cell (
            .clk(clk), .load(copy), .load_pt(store[i]), .step(step), .t(t_reg),
            .right_pt(cpt[i+1]), .pt(cpt[i]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (copy) state_next = ST_RUN;
            ST_RUN:  if (left_reg == CB'(1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CFG_BITS'(2);
            left_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
            if (copy)
                left_reg <= n_eff - CB'(1);
            else if (step)
                left_reg <= left_reg - CB'(1);
            if (step && left_reg == CB'(1))
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (copy)
            t_reg <= s_axis_tdata[IB+3*COORD_BITS +: T_FRAC_BITS];
    end

    // result word straight from cell 0, which holds until the next copy
    always_comb
    begin
        out_word = '0;
        for (int k = 0; k < AXES; k++)
            out_word[k*COORD_BITS +: COORD_BITS] = cpt[0][k];
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_word;
endmodule
`default_nettype wire

// ----- rtl/bpe_checker.sv -----
`default_nettype none
module bpe_checker (
    input wire clk,
    input wire rst_n,
    input wire s_axis_tvalid,
    input wire s_axis_tready,
    input wire s_axis_tuser,
    input wire m_axis_tvalid,
    input wire m_axis_tready
);
    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    // an accepted evaluate blocks input next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("accepted during evaluation");
    // a load never makes a result
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !m_axis_tvalid)
        else $error("load produced result");
endmodule
bind bezier_point_eval_unit bpe_checker u_chk (.*);
`default_nettype wire
